/* design/fbc8_pkg.sv */
package fbc8_pkg;

  // Number of Feistel rounds, one pipeline cell each (1 to 8)
  localparam int NUM_ROUNDS = 8;
  // Round key registers on the configuration port
  localparam int KEY_COUNT  = 8;
  localparam int KEY_IDX_W  = $clog2(KEY_COUNT);
  localparam int HALF_W     = 32;
  localparam int BLOCK_W    = 2 * HALF_W;
  localparam int BYTES_HALF = HALF_W / 8;

  localparam logic [HALF_W-1:0] ALL_ONES = '1;

  // Request codes
  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  // Data handed from one round cell to the next
  typedef struct packed {
    logic              valid;
    logic              decrypt;
    logic [HALF_W-1:0] left;
    logic [HALF_W-1:0] right;
  } stage_t;

  // Bytewise product, low byte kept; all ones folds to zero
  function automatic logic [HALF_W-1:0] round_fn(input logic [HALF_W-1:0] half,
                                                 input logic [HALF_W-1:0] key);
    logic [HALF_W-1:0] g;
    logic [15:0]       prod;
    g = '0;
    for (int b = 0; b < BYTES_HALF; b++) begin
      prod = half[b*8 +: 8] * key[b*8 +: 8];
      g[b*8 +: 8] = prod[7:0];
    end
    return (g == ALL_ONES) ? '0 : g;
  endfunction

endpackage

/* design/fbc8_round_cell.sv */
module fbc8_round_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fbc8_pkg::stage_t              stage_in,
  input  logic [fbc8_pkg::HALF_W-1:0]   key_fwd,
  input  logic [fbc8_pkg::HALF_W-1:0]   key_rev,
  output fbc8_pkg::stage_t              stage_out
);

  fbc8_pkg::stage_t            stage_r;
  fbc8_pkg::stage_t            stage_nxt;
  logic [fbc8_pkg::HALF_W-1:0] key;

  // Key pick follows the request direction carried with the data
  assign key = (stage_in.decrypt == fbc8_pkg::REQ_DECRYPT) ? key_rev : key_fwd;

  // One Feistel round
  always_comb begin
    stage_nxt         = stage_in;
    stage_nxt.left    = stage_in.right;
    stage_nxt.right   = stage_in.left ^ fbc8_pkg::round_fn(stage_in.right, key);
  end

  // Valid is control and gets reset; data rides along unreset
  always_ff @(posedge clk) begin
    stage_r.decrypt <= stage_nxt.decrypt;
    stage_r.left    <= stage_nxt.left;
    stage_r.right   <= stage_nxt.right;
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
  end

  assign stage_out = stage_r;

  // A request moves exactly one cell per cycle
  a_valid_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> stage_r.valid == $past(stage_in.valid))
    else $error("round cell dropped or invented a request");

  // The swapped half must come through unchanged
  a_left_from_right: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && stage_r.valid) |-> stage_r.left == $past(stage_in.right))
    else $error("round cell left half mismatch");

  // Direction bit travels with its request
  a_dir_carried: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && stage_r.valid) |-> stage_r.decrypt == $past(stage_in.decrypt))
    else $error("round cell direction mismatch");

endmodule

/* design/feistel_block_cipher_8_round.sv */
// 8-round Feistel cipher on 64-bit blocks, one round cell per pipeline stage.
// A request (start high while busy is low) is taken every cycle; busy never
// rises. Each result appears on out_result_block with out_valid high for one
// cycle, in request order, after it has passed the registers of all NUM_ROUNDS
// (8) round cells in the chain. The receiver cannot stall the output. Round
// keys are written through cfg_* (always ready) and must only change while no
// request is in flight.
module feistel_block_cipher_8_round (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_req_type,
  input  logic [fbc8_pkg::BLOCK_W-1:0]      in_data_block,
  // result channel
  output logic                              out_valid,
  output logic [fbc8_pkg::BLOCK_W-1:0]      out_result_block,
  // key register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fbc8_pkg::KEY_IDX_W-1:0]    cfg_index,
  input  logic [fbc8_pkg::HALF_W-1:0]       cfg_data
);

  logic [fbc8_pkg::HALF_W-1:0] keys_r [fbc8_pkg::KEY_COUNT];
  fbc8_pkg::stage_t            stages [fbc8_pkg::NUM_ROUNDS+1];
  fbc8_pkg::stage_t            last;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fbc8_pkg::KEY_COUNT; i++) begin
        keys_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      keys_r[cfg_index] <= cfg_data;
    end
  end

  // Chain entry
  always_comb begin
    stages[0].valid   = start && !busy;
    stages[0].decrypt = in_req_type;
    stages[0].left    = in_data_block[fbc8_pkg::BLOCK_W-1:fbc8_pkg::HALF_W];
    stages[0].right   = in_data_block[fbc8_pkg::HALF_W-1:0];
  end

  // Round cells; decryption walks the keys from the last round down
  for (genvar j = 0; j < fbc8_pkg::NUM_ROUNDS; j++) begin : g_round
    localparam int FWD = j;
    localparam int REV = fbc8_pkg::NUM_ROUNDS - 1 - j;
    fbc8_round_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_in  (stages[j]),
      .key_fwd   (keys_r[fbc8_pkg::KEY_IDX_W'(FWD)]),
      .key_rev   (keys_r[fbc8_pkg::KEY_IDX_W'(REV)]),
      .stage_out (stages[j+1])
    );
  end

  // Halves leave swapped
  assign last             = stages[fbc8_pkg::NUM_ROUNDS];
  assign out_valid        = last.valid;
  assign out_result_block = {last.right, last.left};

  a_out_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result strobe right after reset");

  a_key_write: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(cfg_valid && cfg_ready)) |->
      keys_r[$past(cfg_index)] == $past(cfg_data))
    else $error("key register write lost");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy)
    else $error("request refused");

endmodule
